// ----- rtl/pitp_pkg.sv -----
package pitp_pkg;

    localparam int PHASE_W = 16;
    localparam int SPEED_W = 32;
    localparam int ERR_W   = 16;
    localparam int KP_W    = 16;
    localparam int KI_W    = 24;
    localparam int DT_W    = 32;
    localparam int LIM_W   = 31;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int INC_W  = 42;
    localparam int SUM_W  = 43;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT   = 2'd3;

    localparam logic [LIM_W-1:0] SPEED_LIMIT_RESET = {LIM_W{1'b1}};

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_CAPTURE  = 4'd1;
    localparam logic [3:0] OP_MUL_T    = 4'd2;
    localparam logic [3:0] OP_MUL_LO   = 4'd3;
    localparam logic [3:0] OP_MUL_HI   = 4'd4;
    localparam logic [3:0] OP_MUL_KP   = 4'd5;
    localparam logic [3:0] OP_SUM      = 4'd6;
    localparam logic [3:0] OP_RATE     = 4'd7;
    localparam logic [3:0] OP_MUL_RATE = 4'd8;
    localparam logic [3:0] OP_UPDATE   = 4'd9;
    localparam logic [3:0] OP_PUSH     = 4'd10;

    typedef struct packed {
        logic [3:0] op;
    } pitp_cmd_t;

    typedef struct packed {
        logic load;
    } pitp_status_t;

endpackage

// ----- rtl/pitp_ctrl.sv -----
module pitp_ctrl
    import pitp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  pitp_status_t status,
    output pitp_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MT    = 4'd1;
    localparam logic [3:0] S_ML    = 4'd2;
    localparam logic [3:0] S_MH    = 4'd3;
    localparam logic [3:0] S_MK    = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_RATE  = 4'd6;
    localparam logic [3:0] S_MR    = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;
    localparam logic [3:0] S_PUSH  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = OP_NONE;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_CAPTURE;
                    state_next = status.load ? S_PUSH : S_MT;
                end
            end
            S_MT: begin
                cmd.op     = OP_MUL_T;
                state_next = S_ML;
            end
            S_ML: begin
                cmd.op     = OP_MUL_LO;
                state_next = S_MH;
            end
            S_MH: begin
                cmd.op     = OP_MUL_HI;
                state_next = S_MK;
            end
            S_MK: begin
                cmd.op     = OP_MUL_KP;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.op     = OP_SUM;
                state_next = S_RATE;
            end
            S_RATE: begin
                cmd.op     = OP_RATE;
                state_next = S_MR;
            end
            S_MR: begin
                cmd.op     = OP_MUL_RATE;
                state_next = S_UPD;
            end
            S_UPD: begin
                cmd.op     = OP_UPDATE;
                state_next = S_PUSH;
            end
            S_PUSH: begin
                // hold until the output word is free
                if (!out_valid_reg || m_tready) begin
                    cmd.op         = OP_PUSH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_push_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PUSH && out_valid_reg && !m_tready) |=> (state_reg == S_PUSH))
        else $error("push left while output word stalled");

    a_step_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !status.load) |=> (state_reg == S_MT))
        else $error("loop step did not start");

    a_load_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && status.load) |=> (state_reg == S_PUSH))
        else $error("load word did not go straight to push");

    a_push_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_PUSH) |=> m_tvalid)
        else $error("pushed word not presented");

endmodule

// ----- rtl/pitp_dp.sv -----
module pitp_dp
    import pitp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic [PHASE_W-1:0]   in_phase,
    input  logic                 in_load,
    input  pitp_cmd_t            cmd,
    output pitp_status_t         status,
    output logic [PHASE_W-1:0]   out_phase,
    output logic [SPEED_W-1:0]   out_speed,
    output logic [ERR_W-1:0]     out_error
);

    logic [KP_W-1:0]  kp_reg;
    logic [KI_W-1:0]  ki_reg;
    logic [DT_W-1:0]  dt_reg;
    logic [LIM_W-1:0] lim_reg;

    logic [PHASE_W-1:0]       phase_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [ERR_W-1:0]  err_reg;

    logic signed [ERR_W-1:0]   e_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [KI_W-1:0]           hi_reg;
    logic signed [15:0]        frac_reg;
    logic signed [INC_W-1:0]   inc_reg;
    logic signed [SPEED_W-1:0] s_reg;
    logic signed [MUL_W-1:0]   kpe_reg;
    logic signed [MUL_W-1:0]   rate_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [MUL_W-1:0]  e_ext;
    logic signed [SUM_W-1:0]  sum_w, lim_pos, lim_neg;
    logic signed [SPEED_W-1:0] s_next;
    logic signed [INC_W-1:0]  inc_next;

    assign status.load = in_load;

    assign e_ext = {{(MUL_W-ERR_W){e_reg[ERR_W-1]}}, e_reg};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_T: begin
                mul_a = {{(MUL_W-KI_W){1'b0}}, ki_reg};
                mul_b = {1'b0, dt_reg};
            end
            OP_MUL_LO: begin
                mul_a = {1'b0, prod_reg[31:0]};
                mul_b = e_ext;
            end
            OP_MUL_HI: begin
                mul_a = {{(MUL_W-KI_W){1'b0}}, hi_reg};
                mul_b = e_ext;
            end
            OP_MUL_KP: begin
                mul_a = {{(MUL_W-KP_W){1'b0}}, kp_reg};
                mul_b = e_ext;
            end
            OP_MUL_RATE: begin
                mul_a = rate_reg;
                mul_b = {1'b0, dt_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // hi*e plus floor(lo*e / 2^32)
    assign inc_next = {prod_reg[40], prod_reg[40:0]}
                    + {{(INC_W-16){frac_reg[15]}}, frac_reg};

    // clamp the integrator to +/- limit
    always_comb begin
        sum_w   = {{(SUM_W-SPEED_W){speed_reg[SPEED_W-1]}}, speed_reg}
                + {inc_reg[INC_W-1], inc_reg};
        lim_pos = {{(SUM_W-LIM_W){1'b0}}, lim_reg};
        lim_neg = -lim_pos;
        if (sum_w > lim_pos) begin
            s_next = lim_pos[SPEED_W-1:0];
        end else if (sum_w < lim_neg) begin
            s_next = lim_neg[SPEED_W-1:0];
        end else begin
            s_next = sum_w[SPEED_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg  <= '0;
            ki_reg  <= '0;
            dt_reg  <= '0;
            lim_reg <= SPEED_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PROP_GAIN:     kp_reg  <= cfg_wr_data[KP_W-1:0];
                CFG_INTEGRAL_GAIN: ki_reg  <= cfg_wr_data[KI_W-1:0];
                CFG_SAMPLE_PERIOD: dt_reg  <= cfg_wr_data[DT_W-1:0];
                CFG_SPEED_LIMIT:   lim_reg <= cfg_wr_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            speed_reg <= '0;
            err_reg   <= '0;
        end else begin
            case (cmd.op)
                OP_CAPTURE: begin
                    if (in_load) begin
                        phase_reg <= in_phase;
                        speed_reg <= '0;
                        err_reg   <= '0;
                    end
                end
                OP_UPDATE: begin
                    phase_reg <= phase_reg + prod_reg[47:32];
                    speed_reg <= s_reg;
                    err_reg   <= e_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CAPTURE:  e_reg <= in_phase - phase_reg;
            OP_MUL_T:    prod_reg <= prod_next;
            OP_MUL_LO: begin
                hi_reg   <= prod_reg[55:32];
                prod_reg <= prod_next;
            end
            OP_MUL_HI: begin
                frac_reg <= prod_reg[47:32];
                prod_reg <= prod_next;
            end
            OP_MUL_KP: begin
                inc_reg  <= inc_next;
                prod_reg <= prod_next;
            end
            OP_SUM: begin
                s_reg   <= s_next;
                kpe_reg <= prod_reg[MUL_W-1:0];
            end
            OP_RATE:     rate_reg <= {s_reg[SPEED_W-1], s_reg} + kpe_reg;
            OP_MUL_RATE: prod_reg <= prod_next;
            OP_PUSH: begin
                out_phase <= phase_reg;
                out_speed <= speed_reg;
                out_error <= err_reg;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/pi_phase_tracking_pll_top.sv -----
// A loop word steps through capture, the T, LO, HI and KP multiplies, sum and clamp, rate,
// rate multiply, update and push; a load word goes from capture straight to push. Five
// passes go through the one shared 33x33 multiplier; no new word is taken before the push.
// The next word is taken while the previous result waits in the output register.
// Reset (aresetn low, synchronous): phase, speed and error clear, gains and dt clear,
// speed limit returns to its maximum, no output word is valid.
module pi_phase_tracking_pll_top
    import pitp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] measured_phase
    input  logic [0:0]           s_tuser,   // [0] load_phase
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata    // [15:0] tracked_phase, [47:16] tracked_speed,
                                            // [63:48] angle_error
);

    pitp_cmd_t    cmd;
    pitp_status_t status;
    logic [PHASE_W-1:0] out_phase;
    logic [SPEED_W-1:0] out_speed;
    logic [ERR_W-1:0]   out_error;

    pitp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pitp_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_phase    (s_tdata[PHASE_W-1:0]),
        .in_load     (s_tuser[0]),
        .cmd         (cmd),
        .status      (status),
        .out_phase   (out_phase),
        .out_speed   (out_speed),
        .out_error   (out_error)
    );

    assign m_tdata = {out_error, out_speed, out_phase};

endmodule

// ----- test/pi_phase_tracking_pll_top_tb.sv -----
module pi_phase_tracking_pll_top_tb;
    import pitp_pkg::*;

    localparam int SEG_ITEMS   = 190;
    localparam int SEG_COUNT   = 6;
    localparam int SETTLE      = 20;
    localparam int HOLD_LEN    = 80;
    localparam int STALL_LIMIT = 1000;
    localparam int DIR_ROWS    = 21;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [SPEED_W-1:0] speed;
        logic [ERR_W-1:0]   err;
    } tracked_t;

    typedef struct packed {
        logic [CFG_W-1:0] kp;
        logic [CFG_W-1:0] ki;
        logic [CFG_W-1:0] dt;
        logic [CFG_W-1:0] lim;
    } reg_set_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_SETUP} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [PHASE_W-1:0] meas;
        logic               load;
        tracked_t           want;
        reg_set_t           regs;
    } dir_row_t;

    // upper register bits carry junk on purpose; the block must drop them
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{ROW_TYPED,   16'h0000, 1'b0, '{16'h0000, 32'd0, 16'h0000}, '0},
        '{ROW_TYPED,   16'h7FFF, 1'b0, '{16'h0000, 32'd0, 16'h7FFF}, '0},
        '{ROW_TYPED,   16'h8000, 1'b0, '{16'h0000, 32'd0, 16'h8000}, '0},
        '{ROW_TYPED,   16'hFFFF, 1'b0, '{16'h0000, 32'd0, 16'hFFFF}, '0},
        '{ROW_TYPED,   16'hFFFF, 1'b1, '{16'hFFFF, 32'd0, 16'h0000}, '0},
        '{ROW_TYPED,   16'h0000, 1'b0, '{16'hFFFF, 32'd0, 16'h0001}, '0},
        '{ROW_SETUP,   16'h0000, 1'b0, '0,
          '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
        '{ROW_PREDICT, 16'h7FFF, 1'b0, '0, '0},
        '{ROW_PREDICT, 16'h8000, 1'b0, '0, '0},
        '{ROW_PREDICT, 16'h1234, 1'b0, '0, '0},
        '{ROW_TYPED,   16'h4000, 1'b1, '{16'h4000, 32'd0, 16'h0000}, '0},
        '{ROW_PREDICT, 16'hC000, 1'b0, '0, '0},
        '{ROW_PREDICT, 16'h4100, 1'b0, '0, '0},
        // shrink the limit below the stored speed
        '{ROW_SETUP,   16'h0000, 1'b0, '0,
          '{32'h0000_0001, 32'h0000_0001, 32'h0001_0000, 32'h0000_03E8}},
        '{ROW_PREDICT, 16'h4200, 1'b0, '0, '0},
        '{ROW_PREDICT, 16'h3F00, 1'b0, '0, '0},
        '{ROW_SETUP,   16'h0000, 1'b0, '0,
          '{32'hFFFF_0000, 32'h0000_FFFF, 32'h0100_0000, 32'h8000_0000}},
        '{ROW_PREDICT, 16'h9000, 1'b0, '0, '0},
        '{ROW_PREDICT, 16'h1000, 1'b0, '0, '0},
        '{ROW_TYPED,   16'h0000, 1'b1, '{16'h0000, 32'd0, 16'h0000}, '0},
        '{ROW_TYPED,   16'h2000, 1'b0, '{16'h0000, 32'd0, 16'h2000}, '0}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;

    // loop model state and register copies
    logic [PHASE_W-1:0]        est_phase;
    logic signed [SPEED_W-1:0] est_speed;
    logic [ERR_W-1:0]          est_err;
    logic [KP_W-1:0]           kp_reg;
    logic [KI_W-1:0]           ki_reg;
    logic [DT_W-1:0]           dt_reg;
    logic [LIM_W-1:0]          lim_reg;

    tracked_t pending_track [$];
    int       bad_cnt;
    int       src_idle;
    int       sink_idle;
    bit       sink_hold_go;

    pi_phase_tracking_pll_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic tracked_t pll_predict(input logic [PHASE_W-1:0] meas, input logic load);
        logic signed [ERR_W-1:0] err;
        logic signed [95:0] err_x, kp_x, ki_x, dt_x, lim_x, sum_x, rate_x, prod_x;
        tracked_t res;
        if (load) begin
            est_phase = meas;
            est_speed = '0;
            est_err   = '0;
        end else begin
            err   = meas - est_phase;
            err_x = {{(96-ERR_W){err[ERR_W-1]}}, err};
            kp_x  = {{(96-KP_W){1'b0}}, kp_reg};
            ki_x  = {{(96-KI_W){1'b0}}, ki_reg};
            dt_x  = {{(96-DT_W){1'b0}}, dt_reg};
            lim_x = {{(96-LIM_W){1'b0}}, lim_reg};
            sum_x = {{(96-SPEED_W){est_speed[SPEED_W-1]}}, est_speed};
            // arithmetic shift floors toward minus infinity
            sum_x = sum_x + ((ki_x * dt_x * err_x) >>> 32);
            if (sum_x > lim_x) sum_x = lim_x;
            if (sum_x < -lim_x) sum_x = -lim_x;
            rate_x    = sum_x + kp_x * err_x;
            prod_x    = rate_x * dt_x;
            est_speed = sum_x[SPEED_W-1:0];
            est_phase = est_phase + prod_x[47:32];
            est_err   = err;
        end
        res.phase = est_phase;
        res.speed = est_speed;
        res.err   = est_err;
        return res;
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg(input logic [CFG_W-1:0] mask,
                                                  input int unsigned typical);
        logic [CFG_W-1:0] v;
        case ($urandom_range(5))
            0: v = '0;
            1: v = mask;
            2, 3: v = $urandom_range(typical);
            default: v = $urandom();
        endcase
        return (v & mask) | ($urandom() & ~mask);
    endfunction

    task automatic write_regs(input reg_set_t regs);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_PROP_GAIN;
        cfg_wr_data <= regs.kp;
        @(posedge aclk);
        cfg_index   <= CFG_INTEGRAL_GAIN;
        cfg_wr_data <= regs.ki;
        @(posedge aclk);
        cfg_index   <= CFG_SAMPLE_PERIOD;
        cfg_wr_data <= regs.dt;
        @(posedge aclk);
        cfg_index   <= CFG_SPEED_LIMIT;
        cfg_wr_data <= regs.lim;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        kp_reg  = regs.kp[KP_W-1:0];
        ki_reg  = regs.ki[KI_W-1:0];
        dt_reg  = regs.dt[DT_W-1:0];
        lim_reg = regs.lim[LIM_W-1:0];
    endtask

    // leave s_tvalid high on return so back-to-back words need no toggle
    task automatic send_word(input logic [PHASE_W-1:0] meas, input logic load,
                             input bit typed, input tracked_t typed_want);
        tracked_t want;
        s_tvalid <= 1'b1;
        s_tdata  <= meas;
        s_tuser  <= load;
        do @(posedge aclk); while (!s_tready);
        want = pll_predict(meas, load);
        pending_track.push_back(typed ? typed_want : want);
    endtask

    task automatic src_gap();
        int n;
        if (src_idle != 0 && $urandom_range(99) < src_idle) begin
            n = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_track.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic flag_diff(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
        bad_cnt++;
        if (bad_cnt <= 10)
            $display("mismatch in %s: expected %h, got %h", field, want_v, got_v);
    endtask

    // result checker
    always @(posedge aclk) begin
        tracked_t got;
        tracked_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.phase = m_tdata[15:0];
            got.speed = m_tdata[47:16];
            got.err   = m_tdata[63:48];
            if (pending_track.size() == 0) begin
                bad_cnt++;
                if (bad_cnt <= 10)
                    $display("result word with nothing pending: %h", m_tdata);
            end else begin
                want = pending_track.pop_front();
                if (got.phase !== want.phase) flag_diff("tracked_phase", want.phase, got.phase);
                if (got.speed !== want.speed) flag_diff("tracked_speed", want.speed, got.speed);
                if (got.err !== want.err) flag_diff("angle_error", want.err, got.err);
            end
        end
    end

    // result sink with random backpressure and one-shot long hold
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold_go) begin
                sink_hold_go = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        reg_set_t           regs;
        logic [PHASE_W-1:0] meas;
        logic [PHASE_W-1:0] spin;
        logic [PHASE_W-1:0] spin_step;
        logic               load;
        int                 sel;
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= CFG_PROP_GAIN;
        cfg_wr_data  <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        bad_cnt      = 0;
        src_idle     = 0;
        sink_idle    = 0;
        sink_hold_go = 1'b0;
        est_phase    = '0;
        est_speed    = '0;
        est_err      = '0;
        kp_reg       = '0;
        ki_reg       = '0;
        dt_reg       = '0;
        lim_reg      = SPEED_LIMIT_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TAB[r].kind == ROW_SETUP) begin
                drain();
                write_regs(DIR_TAB[r].regs);
            end else begin
                send_word(DIR_TAB[r].meas, DIR_TAB[r].load,
                          DIR_TAB[r].kind == ROW_TYPED, DIR_TAB[r].want);
            end
        end

        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            drain();
            regs.kp  = pick_reg(32'h0000_FFFF, 4000);
            regs.ki  = pick_reg(32'h00FF_FFFF, 1 << 22);
            regs.dt  = pick_reg(32'hFFFF_FFFF, 1 << 20);
            regs.lim = pick_reg(32'h7FFF_FFFF, 1 << 24);
            write_regs(regs);
            src_idle  = (seg < 2) ? 31 : (seg < 4) ? 65 : 0;
            sink_idle = (seg < 2) ? 65 : (seg < 4) ? 31 : 0;
            spin      = 16'($urandom());
            spin_step = 16'($urandom_range(1500)) - 16'd750;
            for (int k = 0; k < SEG_ITEMS; k++) begin
                // stall the sink while words keep coming so the input backs up
                if (k == 0 && (seg == 0 || seg == 4)) sink_hold_go = 1'b1;
                if (k == SEG_ITEMS / 2) drain();
                src_gap();
                sel  = $urandom_range(99);
                load = 1'b0;
                if (sel < 35) begin
                    meas = 16'($urandom());
                end else if (sel < 75) begin
                    meas = est_phase + 16'($urandom_range(512)) - 16'd256;
                end else if (sel < 95) begin
                    spin = spin + spin_step;
                    meas = spin + 16'($urandom_range(31));
                end else begin
                    meas = 16'($urandom());
                    load = 1'b1;
                end
                send_word(meas, load, 1'b0, '0);
            end
        end

        drain();
        if (bad_cnt == 0 && pending_track.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
